/* hdl/uvs_pkg.sv */
package uvs_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned NORMAL_FRAC_BITS_DEF = 14;
  localparam int unsigned MAX_TESS_DEF         = 255;

  // Field and datapath widths.
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned NORM_W    = 16;
  localparam int unsigned TEX_W     = 17;
  localparam int unsigned CORNER_W  = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIV_W     = 40;  // dividend width, one stage per bit
  localparam int unsigned DVS_W     = 9;   // divisor width (twice the latitude count)
  localparam int unsigned SC_LAT    = 12;  // sine/cosine unit latency
  localparam int unsigned PIPE_LAT  = 1 + DIV_W + SC_LAT + 2;

  // Q30 constants.
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [30:0] HALF_PI_Q30 = 31'h6487_ED51;

  // Reciprocals for division by small odd constants: q = (v * M) >> K.
  localparam int unsigned DIV3_K  = 32;
  localparam int unsigned DIV5_K  = 33;
  localparam int unsigned DIV7_K  = 33;
  localparam int unsigned DIV9_K  = 34;
  localparam int unsigned DIV15_K = 34;
  localparam int unsigned DIV21_K = 35;
  localparam int unsigned DIV45_K = 36;
  localparam logic [31:0] DIV3_M  = 32'(((64'd1 << 32) + 64'd2) / 64'd3);
  localparam logic [31:0] DIV5_M  = 32'(((64'd1 << 33) + 64'd4) / 64'd5);
  localparam logic [31:0] DIV7_M  = 32'(((64'd1 << 33) + 64'd6) / 64'd7);
  localparam logic [31:0] DIV9_M  = 32'(((64'd1 << 34) + 64'd8) / 64'd9);
  localparam logic [31:0] DIV15_M = 32'(((64'd1 << 34) + 64'd14) / 64'd15);
  localparam logic [31:0] DIV21_M = 32'(((64'd1 << 35) + 64'd20) / 64'd21);
  localparam logic [31:0] DIV45_M = 32'(((64'd1 << 36) + 64'd44) / 64'd45);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TESS_LON = 2'd0,
    CFG_TESS_LAT = 2'd1
  } cfg_reg_e;

  // Per-item side information that travels beside the trig datapath.
  typedef struct packed {
    logic                pole_n;
    logic                pole_s;
    logic                vtx_ok;
    logic                quad_ok;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic [CORNER_W-1:0] corner_d;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } side_tex_t;

  // Exact floor division of a Q30 value by an odd constant.
  function automatic logic [29:0] div_odd(input logic [29:0] v, input logic [31:0] m,
                                          input int unsigned k);
    logic [61:0] p;
    p = 62'(v) * 62'(m);
    return 30'(p >> k);
  endfunction

  // Q60 signed to Q(fb), round half away from zero, saturate to 16 bits.
  function automatic logic [NORM_W-1:0] q60_to_field(input logic signed [63:0] v,
                                                     input int unsigned fb);
    logic        neg;
    logic [63:0] m;
    neg = v[63];
    m   = neg ? (64'd0 - 64'(v)) : 64'(v);
    m   = (m + (64'd1 << (59 - fb))) >> (60 - fb);
    if (neg) begin
      if (m > 64'd32768) m = 64'd32768;
      return 16'(64'd0 - m);
    end
    if (m > 64'd32767) m = 64'd32767;
    return 16'(m);
  endfunction

endpackage

/* hdl/uv_sphere_vertex_generator.sv */
// Channel   | Direction | Handshake                    | Payload
// ----------+-----------+------------------------------+--------------------------------
// item      | in        | start / busy                 | lon_index_i, lat_index_i
// result    | out       | result_valid_o strobe        | normal xyz, tex uv, corners, flags
// config    | in        | cfg_valid_i / cfg_ready_o    | cfg_index_i, cfg_data_i
//
// One beat is taken every cycle; busy never rises.
// The datapath is an input register, 40-stage pipelined divider for the phases and
// texture coordinates, 12-stage sine/cosine unit, product stage and output register.
// Reset clears the valid bits and loads tess_lon = 128, tess_lat = 64.
// The result strobe cannot be held off, so the pipeline never stalls.
module uv_sphere_vertex_generator #(
  parameter int unsigned NORMAL_FRAC_BITS = uvs_pkg::NORMAL_FRAC_BITS_DEF,
  parameter int unsigned MAX_TESS         = uvs_pkg::MAX_TESS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [uvs_pkg::IDX_W-1:0]           lon_index_i,
  input  logic [uvs_pkg::IDX_W-1:0]           lat_index_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [uvs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  output logic                                result_valid_o,
  output logic signed [uvs_pkg::NORM_W-1:0]   normal_x_o,
  output logic signed [uvs_pkg::NORM_W-1:0]   normal_y_o,
  output logic signed [uvs_pkg::NORM_W-1:0]   normal_z_o,
  output logic [uvs_pkg::TEX_W-1:0]           tex_u_o,
  output logic [uvs_pkg::TEX_W-1:0]           tex_v_o,
  output logic [uvs_pkg::CORNER_W-1:0]        corner_a_o,
  output logic [uvs_pkg::CORNER_W-1:0]        corner_b_o,
  output logic [uvs_pkg::CORNER_W-1:0]        corner_c_o,
  output logic [uvs_pkg::CORNER_W-1:0]        corner_d_o,
  output logic                                vertex_valid_o,
  output logic                                quad_valid_o
);

  localparam int unsigned DW = uvs_pkg::DIV_W;
  localparam int unsigned VW = uvs_pkg::DVS_W;

  logic accept;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Configuration registers.
  logic [7:0] tess_lon_q, tess_lat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tess_lon_q <= 8'd128;
      tess_lat_q <= 8'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        uvs_pkg::CFG_TESS_LON: tess_lon_q <= cfg_data_i;
        uvs_pkg::CFG_TESS_LAT: tess_lat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp the counts into [3, MAX_TESS].
  function automatic logic [7:0] eff_tess(input logic [7:0] t);
    if (t < 8'd3) return 8'd3;
    if (t > 8'(MAX_TESS)) return 8'(MAX_TESS);
    return t;
  endfunction

  // Input register.
  logic       e_valid_q;
  logic [7:0] i_q, j_q, tl_q, tt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else begin
      e_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q  <= lon_index_i;
    j_q  <= lat_index_i;
    tl_q <= eff_tess(tess_lon_q);
    tt_q <= eff_tess(tess_lat_q);
  end

  // Corner indices, validity and pole flags.
  uvs_pkg::side_t side_e;
  logic [8:0]     stride;
  logic [16:0]    base;

  always_comb begin
    stride          = {1'b0, tl_q} + 9'd1;
    base            = 17'(j_q) * 17'(stride);
    side_e.pole_n   = (j_q == 8'd0);
    side_e.pole_s   = (j_q >= tt_q);
    side_e.vtx_ok   = (i_q <= tl_q) && (j_q <= tt_q);
    side_e.quad_ok  = (i_q < tl_q) && (j_q < tt_q);
    side_e.corner_a = 16'(base) + 16'(i_q);
    side_e.corner_b = side_e.corner_a + 16'd1;
    side_e.corner_d = side_e.corner_a + 16'(stride);
    side_e.corner_c = side_e.corner_d + 16'd1;
  end

  // Phase and texture dividers.
  logic [DW-1:0] q_lon, q_col, q_u, q_v;

  uvs_div #(.DW(DW), .VW(VW)) u_div_lon (
    .clk_i      (clk_i),
    .dividend_i ({i_q, 25'd0, tl_q[7:1]}),
    .divisor_i  ({1'b0, tl_q}),
    .quotient_o (q_lon)
  );

  uvs_div #(.DW(DW), .VW(VW)) u_div_col (
    .clk_i      (clk_i),
    .dividend_i ({j_q, 24'd0, tt_q}),
    .divisor_i  ({tt_q, 1'b0}),
    .quotient_o (q_col)
  );

  uvs_div #(.DW(DW), .VW(VW)) u_div_u (
    .clk_i      (clk_i),
    .dividend_i ({16'd0, i_q, 9'd0, tl_q[7:1]}),
    .divisor_i  ({1'b0, tl_q}),
    .quotient_o (q_u)
  );

  uvs_div #(.DW(DW), .VW(VW)) u_div_v (
    .clk_i      (clk_i),
    .dividend_i ({16'd0, j_q, 9'd0, tt_q[7:1]}),
    .divisor_i  ({1'b0, tt_q}),
    .quotient_o (q_v)
  );

  // Side information across the dividers.
  logic                     d_valid;
  logic [$bits(uvs_pkg::side_t)-1:0] side_d_bits;

  uvs_delay #(.W($bits(uvs_pkg::side_t)), .DEPTH(DW)) u_dly_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_valid_q),
    .data_i  (side_e),
    .valid_o (d_valid),
    .data_o  (side_d_bits)
  );

  // Saturate texture coordinates and join them to the side bundle.
  uvs_pkg::side_tex_t st_d;

  always_comb begin
    st_d.side  = uvs_pkg::side_t'(side_d_bits);
    st_d.tex_u = (q_u > DW'(65536)) ? 17'h1_0000 : q_u[16:0];
    st_d.tex_v = (q_v > DW'(65536)) ? 17'h1_0000 : q_v[16:0];
  end

  // Sine and cosine of longitude and colatitude.
  logic signed [31:0] slon, clon, scol, ccol;

  uvs_sincos u_sc_lon (
    .clk_i   (clk_i),
    .phase_i (q_lon[31:0]),
    .sin_o   (slon),
    .cos_o   (clon)
  );

  uvs_sincos u_sc_col (
    .clk_i   (clk_i),
    .phase_i (q_col[31:0]),
    .sin_o   (scol),
    .cos_o   (ccol)
  );

  logic                                  c_valid;
  logic [$bits(uvs_pkg::side_tex_t)-1:0] st_c_bits;
  uvs_pkg::side_tex_t                    st_c;

  uvs_delay #(.W($bits(uvs_pkg::side_tex_t)), .DEPTH(uvs_pkg::SC_LAT)) u_dly_sc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d_valid),
    .data_i  (st_d),
    .valid_o (c_valid),
    .data_o  (st_c_bits)
  );

  assign st_c = uvs_pkg::side_tex_t'(st_c_bits);

  // Products in Q60, poles substituted.
  localparam logic signed [63:0] Q60_ONE = 64'sh1000_0000_0000_0000;

  logic                 p_valid_q;
  uvs_pkg::side_tex_t   st_p_q;
  logic signed [63:0]   vx_q, vy_q, vz_q;
  logic signed [63:0]   vx_d, vy_d, vz_d;

  always_comb begin
    if (st_c.side.pole_n) begin
      vx_d = '0;
      vy_d = Q60_ONE;
      vz_d = '0;
    end else if (st_c.side.pole_s) begin
      vx_d = '0;
      vy_d = -Q60_ONE;
      vz_d = '0;
    end else begin
      vx_d = 64'(scol) * 64'(clon);
      vy_d = 64'(ccol) <<< 30;
      vz_d = 64'(scol) * 64'(slon);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q      <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      p_valid_q      <= c_valid;
      result_valid_o <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    st_p_q <= st_c;
    vx_q   <= vx_d;
    vy_q   <= vy_d;
    vz_q   <= vz_d;
  end

  // Round to the output format and register the result beat.
  always_ff @(posedge clk_i) begin
    normal_x_o     <= $signed(uvs_pkg::q60_to_field(vx_q, NORMAL_FRAC_BITS));
    normal_y_o     <= $signed(uvs_pkg::q60_to_field(vy_q, NORMAL_FRAC_BITS));
    normal_z_o     <= $signed(uvs_pkg::q60_to_field(vz_q, NORMAL_FRAC_BITS));
    tex_u_o        <= st_p_q.tex_u;
    tex_v_o        <= st_p_q.tex_v;
    corner_a_o     <= st_p_q.side.corner_a;
    corner_b_o     <= st_p_q.side.corner_b;
    corner_c_o     <= st_p_q.side.corner_c;
    corner_d_o     <= st_p_q.side.corner_d;
    vertex_valid_o <= st_p_q.side.vtx_ok;
    quad_valid_o   <= st_p_q.side.quad_ok;
  end

  // Every accepted beat comes out after the fixed latency.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(uvs_pkg::PIPE_LAT) result_valid_o)
    else $error("result beat missing after fixed latency");

  // A quad point is always a vertex point.
  a_quad_vtx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && quad_valid_o |-> vertex_valid_o)
    else $error("quad valid without vertex valid");

  // Neighboring corners sit one index apart.
  a_corner : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (corner_b_o == corner_a_o + 16'd1) &&
                       (corner_c_o == corner_d_o + 16'd1))
    else $error("corner indices out of step");

  // Texture coordinates never exceed one.
  a_tex : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (tex_u_o <= 17'h1_0000) && (tex_v_o <= 17'h1_0000))
    else $error("texture coordinate above one");

endmodule

/* hdl/uvs_div.sv */
// Restoring divider, one quotient bit per pipeline stage.
module uvs_div #(
  parameter int unsigned DW = uvs_pkg::DIV_W,
  parameter int unsigned VW = uvs_pkg::DVS_W
) (
  input  logic          clk_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quotient_o
);

  logic [VW-1:0] rem_q  [DW];
  logic [DW-1:0] word_q [DW];
  logic [VW-1:0] dvs_q  [DW];

  for (genvar g = 0; g < DW; g++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [DW-1:0] word_in;
    logic [VW-1:0] dvs_in;
    logic [VW:0]   trial;
    logic          ge;

    // Stage inputs come from the previous stage, or from the ports for the first.
    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign word_in = dividend_i;
      assign dvs_in  = divisor_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign word_in = word_q[g-1];
      assign dvs_in  = dvs_q[g-1];
    end

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_in, word_in[DW-1]};
    assign ge    = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk_i) begin
      rem_q[g]  <= ge ? VW'(trial - {1'b0, dvs_in}) : VW'(trial);
      word_q[g] <= {word_in[DW-2:0], ge};
      dvs_q[g]  <= dvs_in;
    end
  end

  assign quotient_o = word_q[DW-1];

endmodule

/* hdl/uvs_sincos.sv */
// Sine and cosine of a 32-bit turn phase, signed Q30, twelve-stage pipeline.
module uvs_sincos (
  input  logic               clk_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  localparam logic [29:0] HALF_R = 30'h2000_0000;

  // Quadrant and swap flag travel with the angle.
  logic [2:0]  qs_q  [1:11];
  logic [29:0] rr_q;
  logic [29:0] x_q   [2:10];
  logic [29:0] xsq_q [3:10];
  logic [30:0] ts4_q, tc4_q, ts6_q, tc6_q, ts8_q, tc8_q, ts10_q, tc10_q;
  logic [29:0] ps5_q, pc5_q, ps7_q, pc7_q, ps9_q, pc9_q;
  logic [29:0] sin11_q, pc11_q;

  logic [29:0] r_in;
  logic [29:0] rr_d;
  logic        swap_d;
  logic [29:0] x_d;
  logic [29:0] xsq_d;

  // Fold the in-quadrant fraction into [0, 1/8] turn.
  always_comb begin
    r_in = phase_i[29:0];
    if (r_in <= HALF_R) begin
      rr_d   = r_in;
      swap_d = 1'b0;
    end else begin
      rr_d   = 30'(uvs_pkg::Q30_ONE - {1'b0, r_in});
      swap_d = 1'b1;
    end
  end

  // Angle in radians and its square.
  assign x_d   = 30'((61'(rr_q) * 61'(uvs_pkg::HALF_PI_Q30) + 61'(HALF_R)) >> 30);
  assign xsq_d = 30'((60'(x_q[2]) * 60'(x_q[2])) >> 30);

  always_ff @(posedge clk_i) begin
    qs_q[1] <= {phase_i[31:30], swap_d};
    for (int k = 2; k <= 11; k++) qs_q[k] <= qs_q[k-1];
    rr_q    <= rr_d;
    x_q[2]  <= x_d;
    for (int k = 3; k <= 10; k++) x_q[k] <= x_q[k-1];
    xsq_q[3] <= xsq_d;
    for (int k = 4; k <= 10; k++) xsq_q[k] <= xsq_q[k-1];
  end

  // Horner steps: a constant divide, then a product with the square.
  always_ff @(posedge clk_i) begin
    ts4_q  <= uvs_pkg::Q30_ONE
              - 31'(uvs_pkg::div_odd(xsq_q[3] >> 3, uvs_pkg::DIV9_M, uvs_pkg::DIV9_K));
    tc4_q  <= uvs_pkg::Q30_ONE
              - 31'(uvs_pkg::div_odd(xsq_q[3] >> 1, uvs_pkg::DIV45_M, uvs_pkg::DIV45_K));
    ps5_q  <= 30'((61'(xsq_q[4]) * 61'(ts4_q)) >> 30);
    pc5_q  <= 30'((61'(xsq_q[4]) * 61'(tc4_q)) >> 30);
    ts6_q  <= uvs_pkg::Q30_ONE
              - 31'(uvs_pkg::div_odd(ps5_q >> 1, uvs_pkg::DIV21_M, uvs_pkg::DIV21_K));
    tc6_q  <= uvs_pkg::Q30_ONE
              - 31'(uvs_pkg::div_odd(pc5_q >> 3, uvs_pkg::DIV7_M, uvs_pkg::DIV7_K));
    ps7_q  <= 30'((61'(xsq_q[6]) * 61'(ts6_q)) >> 30);
    pc7_q  <= 30'((61'(xsq_q[6]) * 61'(tc6_q)) >> 30);
    ts8_q  <= uvs_pkg::Q30_ONE
              - 31'(uvs_pkg::div_odd(ps7_q >> 2, uvs_pkg::DIV5_M, uvs_pkg::DIV5_K));
    tc8_q  <= uvs_pkg::Q30_ONE
              - 31'(uvs_pkg::div_odd(pc7_q >> 1, uvs_pkg::DIV15_M, uvs_pkg::DIV15_K));
    ps9_q  <= 30'((61'(xsq_q[8]) * 61'(ts8_q)) >> 30);
    pc9_q  <= 30'((61'(xsq_q[8]) * 61'(tc8_q)) >> 30);
    ts10_q <= uvs_pkg::Q30_ONE
              - 31'(uvs_pkg::div_odd(ps9_q >> 1, uvs_pkg::DIV3_M, uvs_pkg::DIV3_K));
    tc10_q <= uvs_pkg::Q30_ONE
              - 31'(uvs_pkg::div_odd(pc9_q >> 2, uvs_pkg::DIV3_M, uvs_pkg::DIV3_K));
    sin11_q <= 30'((61'(x_q[10]) * 61'(ts10_q)) >> 30);
    pc11_q  <= 30'((61'(xsq_q[10]) * 61'(tc10_q)) >> 30);
  end

  logic [30:0] cosv, sinv, fs, fc;
  logic signed [31:0] fs_s, fc_s, sin_d, cos_d;

  // Finish the cosine, undo the fold, clamp and place by quadrant.
  always_comb begin
    cosv = uvs_pkg::Q30_ONE - 31'(pc11_q >> 1);
    sinv = {1'b0, sin11_q};
    fs   = qs_q[11][0] ? cosv : sinv;
    fc   = qs_q[11][0] ? sinv : cosv;
    if (fs > uvs_pkg::Q30_ONE) fs = uvs_pkg::Q30_ONE;
    if (fc > uvs_pkg::Q30_ONE) fc = uvs_pkg::Q30_ONE;
    fs_s = $signed({1'b0, fs});
    fc_s = $signed({1'b0, fc});
    case (qs_q[11][2:1])
      2'd0: begin
        sin_d = fs_s;
        cos_d = fc_s;
      end
      2'd1: begin
        sin_d = fc_s;
        cos_d = -fs_s;
      end
      2'd2: begin
        sin_d = -fs_s;
        cos_d = -fc_s;
      end
      default: begin
        sin_d = -fc_s;
        cos_d = fs_s;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sin_o <= sin_d;
    cos_o <= cos_d;
  end

endmodule

/* hdl/uvs_delay.sv */
// Delay line for side information, with valid bits that reset clears.
module uvs_delay #(
  parameter int unsigned W     = 1,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [W-1:0] data_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [DEPTH-1:0] valid_q;
  logic [W-1:0]     data_q [DEPTH];

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[DEPTH-2:0], valid_i};
    end
  end

  // Payload taps.
  always_ff @(posedge clk_i) begin
    data_q[0] <= data_i;
    for (int k = 1; k < DEPTH; k++) data_q[k] <= data_q[k-1];
  end

  assign valid_o = valid_q[DEPTH-1];
  assign data_o  = data_q[DEPTH-1];

endmodule
